@@ hw/rtl/vpid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_pkg: shared types and constants of the velocity PID
// Widths, bounds, register map and controller states.
// ----------------------------------------------------------------------------
package vpid_pkg;

	localparam int COUNT_WIDTH_DEF = 12;

	localparam int SP_W    = 8;
	localparam int ERR_W   = 13;
	localparam int DERR_W  = 14;
	localparam int INT_W   = 11;
	localparam int SUM_W   = 14;
	localparam int ACC_W   = 21;
	localparam int GAIN_W  = 5;
	localparam int DRIVE_W = 8;

	localparam int SET_MAX    = 100;
	localparam int ERR_MAX    = 4095;
	localparam int ERR_MIN    = -4096;
	localparam int INT_BOUND  = 1000;
	localparam int OUT_BOUND  = 8128;
	localparam int LEAK_SHIFT = 6;
	localparam int LEAK_ROUND = 63;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [2:0] {
		REG_SOFT_MODE   = 3'd0,
		REG_GAIN_P_STD  = 3'd1,
		REG_GAIN_D_STD  = 3'd2,
		REG_GAIN_P_SOFT = 3'd3,
		REG_GAIN_I_SOFT = 3'd4,
		REG_GAIN_D_SOFT = 3'd5,
		REG_SPEED_CAP   = 3'd6
	} reg_idx_t;

	localparam logic       RST_SOFT_MODE   = 1'b0;
	localparam logic [3:0] RST_GAIN_P_STD  = 4'd3;
	localparam logic [3:0] RST_GAIN_D_STD  = 4'd4;
	localparam logic [4:0] RST_GAIN_P_SOFT = 5'd8;
	localparam logic [4:0] RST_GAIN_I_SOFT = 5'd8;
	localparam logic [4:0] RST_GAIN_D_SOFT = 5'd16;
	localparam logic [6:0] RST_SPEED_CAP   = 7'd25;

	typedef enum logic [1:0] {
		TERM_ERR  = 2'd0,
		TERM_DERR = 2'd1,
		TERM_INT  = 2'd2
	} term_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_CALC = 2'd1,
		S_MUL  = 2'd2,
		S_DONE = 2'd3
	} state_t;

endpackage

@@ hw/rtl/vpid_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_in_if / vpid_out_if: valid/ready channels of the velocity PID
// Setpoint and encoder count in, drive value out.
// ----------------------------------------------------------------------------
interface vpid_in_if #(
	parameter int COUNT_WIDTH = vpid_pkg::COUNT_WIDTH_DEF
);
	logic                                 valid;
	logic                                 ready;
	logic signed [vpid_pkg::SP_W-1:0]     target_speed;
	logic signed [COUNT_WIDTH-1:0]        measured_count;

	modport source (output valid, output target_speed, output measured_count, input ready);
	modport sink   (input valid, input target_speed, input measured_count, output ready);
endinterface

interface vpid_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vpid_pkg::DRIVE_W-1:0]  drive_value;

	modport source (output valid, output drive_value, input ready);
	modport sink   (input valid, input drive_value, output ready);
endinterface

@@ hw/rtl/velocity_pid_two_mode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_pid_two_mode: two-mode velocity PID for one motor
// Incremental PID or PID with leaky integral, gains multiplied bit-serially.
// ----------------------------------------------------------------------------
//  channel  | kind      | transaction
//  ---------+-----------+----------------------------------------------
//  sample   | sink      | target_speed, measured_count per period
//  drive    | source    | drive_value per period
//  apb      | slave     | gain, mode and speed cap registers
//
//  From acceptance to a valid result, an item passes an error step, the
//  shared shift-and-add multiplier per gain term (two in standard mode,
//  three in soft mode) and a saturation step; an invalid setpoint skips
//  the multiplier. arst_n resets the configuration, the controller state,
//  the stored error, sum and integral and the output valid, not the datapath.
//  The next item is taken as soon as the controller is idle, even while the
//  last result waits; a stalled drive channel holds the saturation step.
// ----------------------------------------------------------------------------
module velocity_pid_two_mode #(
	parameter int COUNT_WIDTH = vpid_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vpid_in_if.sink                       sample,
	vpid_out_if.source                    drive,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vpid_pkg::PADDR_W-1:0]  paddr,
	input  logic [vpid_pkg::PDATA_W-1:0]  pwdata,
	output logic [vpid_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	// wide enough for setpoint*4 minus any count before clamping
	localparam int DIFF_W = ((COUNT_WIDTH > vpid_pkg::ERR_W) ? COUNT_WIDTH : vpid_pkg::ERR_W) + 1;
	localparam int LEAK_W = vpid_pkg::INT_W + vpid_pkg::LEAK_SHIFT + 1;
	localparam int BIT_W  = $clog2(vpid_pkg::GAIN_W);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic       soft_mode_q;
	logic [3:0] gain_p_std_q;
	logic [3:0] gain_d_std_q;
	logic [4:0] gain_p_soft_q;
	logic [4:0] gain_i_soft_q;
	logic [4:0] gain_d_soft_q;
	logic [6:0] speed_cap_q;

	logic               cfg_wr;
	vpid_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = vpid_pkg::reg_idx_t'(paddr[vpid_pkg::PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_mode_q   <= vpid_pkg::RST_SOFT_MODE;
			gain_p_std_q  <= vpid_pkg::RST_GAIN_P_STD;
			gain_d_std_q  <= vpid_pkg::RST_GAIN_D_STD;
			gain_p_soft_q <= vpid_pkg::RST_GAIN_P_SOFT;
			gain_i_soft_q <= vpid_pkg::RST_GAIN_I_SOFT;
			gain_d_soft_q <= vpid_pkg::RST_GAIN_D_SOFT;
			speed_cap_q   <= vpid_pkg::RST_SPEED_CAP;
		end else if (cfg_wr) begin
			case (cfg_idx)
				vpid_pkg::REG_SOFT_MODE:   soft_mode_q   <= pwdata[0];
				vpid_pkg::REG_GAIN_P_STD:  gain_p_std_q  <= pwdata[3:0];
				vpid_pkg::REG_GAIN_D_STD:  gain_d_std_q  <= pwdata[3:0];
				vpid_pkg::REG_GAIN_P_SOFT: gain_p_soft_q <= pwdata[4:0];
				vpid_pkg::REG_GAIN_I_SOFT: gain_i_soft_q <= pwdata[4:0];
				vpid_pkg::REG_GAIN_D_SOFT: gain_d_soft_q <= pwdata[4:0];
				vpid_pkg::REG_SPEED_CAP:   speed_cap_q   <= pwdata[6:0];
				default: ;  // address past the map: drop the write
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			vpid_pkg::REG_SOFT_MODE:   prdata[0]   = soft_mode_q;
			vpid_pkg::REG_GAIN_P_STD:  prdata[3:0] = gain_p_std_q;
			vpid_pkg::REG_GAIN_D_STD:  prdata[3:0] = gain_d_std_q;
			vpid_pkg::REG_GAIN_P_SOFT: prdata[4:0] = gain_p_soft_q;
			vpid_pkg::REG_GAIN_I_SOFT: prdata[4:0] = gain_i_soft_q;
			vpid_pkg::REG_GAIN_D_SOFT: prdata[4:0] = gain_d_soft_q;
			vpid_pkg::REG_SPEED_CAP:   prdata[6:0] = speed_cap_q;
			default:                   prdata      = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// controller state and item registers
	// ------------------------------------------------------------------
	vpid_pkg::state_t state_q, state_d;

	logic signed [vpid_pkg::ERR_W-1:0]  prev_error_q;
	logic signed [vpid_pkg::SUM_W-1:0]  incr_accum_q;
	logic signed [vpid_pkg::INT_W-1:0]  leaky_int_q;

	logic signed [vpid_pkg::SP_W-1:0]   sp_q;
	logic signed [COUNT_WIDTH-1:0]      cnt_q;
	logic                               skip_q;
	logic signed [vpid_pkg::ERR_W-1:0]  err_q;
	logic signed [vpid_pkg::DERR_W-1:0] derr_q;
	logic signed [vpid_pkg::INT_W-1:0]  leak_new_q;

	// serial multiplier: multiplicand shifts left, gain shifts right
	logic signed [vpid_pkg::ACC_W-1:0]  acc_q;
	logic signed [vpid_pkg::ACC_W-1:0]  mcand_q;
	logic [vpid_pkg::GAIN_W-1:0]        gain_q;
	logic [BIT_W-1:0]                   bit_q;
	vpid_pkg::term_t                    term_q;

	logic out_valid_q;
	logic signed [vpid_pkg::DRIVE_W-1:0] drive_q;

	// ------------------------------------------------------------------
	// error, derivative and leaky integral (valid in S_CALC)
	// ------------------------------------------------------------------
	logic                               sp_bad;
	logic signed [vpid_pkg::SP_W:0]     cap_s;
	logic signed [vpid_pkg::SP_W:0]     sp_c;
	logic signed [DIFF_W-1:0]           diff;
	logic signed [vpid_pkg::ERR_W-1:0]  err_c;
	logic signed [vpid_pkg::DERR_W-1:0] derr_c;
	logic signed [LEAK_W-1:0]           leak_ext;
	logic signed [LEAK_W-1:0]           leak63;
	logic signed [LEAK_W-1:0]           leak_div;
	logic signed [LEAK_W-1:0]           leak_sum;
	logic signed [vpid_pkg::INT_W-1:0]  leak_c;

	always_comb begin
		sp_bad = (sp_q > vpid_pkg::SET_MAX) || (sp_q < -vpid_pkg::SET_MAX) || (sp_q == '0);
		cap_s  = $signed({2'b00, speed_cap_q});
		sp_c   = (vpid_pkg::SP_W + 1)'(sp_q);
		if (soft_mode_q) begin
			if (sp_c > cap_s)
				sp_c = cap_s;
			else if (sp_c < -cap_s)
				sp_c = -cap_s;
		end
		diff = (DIFF_W'(sp_c) <<< 2) - DIFF_W'(cnt_q);
		if (diff > vpid_pkg::ERR_MAX)
			err_c = vpid_pkg::ERR_W'(vpid_pkg::ERR_MAX);
		else if (diff < vpid_pkg::ERR_MIN)
			err_c = vpid_pkg::ERR_W'(vpid_pkg::ERR_MIN);
		else
			err_c = diff[vpid_pkg::ERR_W-1:0];
		derr_c = vpid_pkg::DERR_W'(err_c) - vpid_pkg::DERR_W'(prev_error_q);

		// times 63/64, truncated toward zero
		leak_ext = LEAK_W'(leaky_int_q);
		leak63   = (leak_ext <<< vpid_pkg::LEAK_SHIFT) - leak_ext;
		if (leak63[LEAK_W-1])
			leak_div = (leak63 + LEAK_W'(vpid_pkg::LEAK_ROUND)) >>> vpid_pkg::LEAK_SHIFT;
		else
			leak_div = leak63 >>> vpid_pkg::LEAK_SHIFT;
		leak_sum = leak_div + LEAK_W'(err_c);
		if (leak_sum > vpid_pkg::INT_BOUND)
			leak_c = vpid_pkg::INT_W'(vpid_pkg::INT_BOUND);
		else if (leak_sum < -vpid_pkg::INT_BOUND)
			leak_c = vpid_pkg::INT_W'(-vpid_pkg::INT_BOUND);
		else
			leak_c = leak_sum[vpid_pkg::INT_W-1:0];
	end

	// ------------------------------------------------------------------
	// operand and gain of the next multiplier term
	// ------------------------------------------------------------------
	logic                              last_bit;
	logic                              last_term;
	vpid_pkg::term_t                   term_nx;
	logic signed [vpid_pkg::ACC_W-1:0] op_nx;
	logic [vpid_pkg::GAIN_W-1:0]       gain_nx;

	always_comb begin
		last_bit  = (bit_q == BIT_W'(vpid_pkg::GAIN_W - 1));
		last_term = soft_mode_q ? (term_q == vpid_pkg::TERM_INT) : (term_q == vpid_pkg::TERM_DERR);
		case (term_q)
			vpid_pkg::TERM_ERR: begin
				term_nx = vpid_pkg::TERM_DERR;
				op_nx   = vpid_pkg::ACC_W'(derr_q);
				gain_nx = soft_mode_q ? gain_d_soft_q : {1'b0, gain_d_std_q};
			end
			vpid_pkg::TERM_DERR: begin
				term_nx = vpid_pkg::TERM_INT;
				op_nx   = vpid_pkg::ACC_W'(leak_new_q);
				gain_nx = gain_i_soft_q;
			end
			default: begin
				term_nx = vpid_pkg::TERM_ERR;
				op_nx   = '0;
				gain_nx = '0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// saturation of the accumulated sum
	// ------------------------------------------------------------------
	logic signed [vpid_pkg::SUM_W-1:0] sum_c;

	always_comb begin
		if (acc_q > vpid_pkg::OUT_BOUND)
			sum_c = vpid_pkg::SUM_W'(vpid_pkg::OUT_BOUND);
		else if (acc_q < -vpid_pkg::OUT_BOUND)
			sum_c = vpid_pkg::SUM_W'(-vpid_pkg::OUT_BOUND);
		else
			sum_c = acc_q[vpid_pkg::SUM_W-1:0];
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	logic take;
	logic finish;

	always_comb begin
		state_d = state_q;
		case (state_q)
			vpid_pkg::S_IDLE: if (sample.valid) state_d = vpid_pkg::S_CALC;
			vpid_pkg::S_CALC: state_d = sp_bad ? vpid_pkg::S_DONE : vpid_pkg::S_MUL;
			vpid_pkg::S_MUL:  if (last_bit && last_term) state_d = vpid_pkg::S_DONE;
			vpid_pkg::S_DONE: if (!out_valid_q || drive.ready) state_d = vpid_pkg::S_IDLE;
			default:          state_d = vpid_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		take   = (state_q == vpid_pkg::S_IDLE) && sample.valid;
		finish = (state_q == vpid_pkg::S_DONE) && (!out_valid_q || drive.ready);
	end

	assign sample.ready      = (state_q == vpid_pkg::S_IDLE);
	assign drive.valid       = out_valid_q;
	assign drive.drive_value = drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vpid_pkg::S_IDLE;
			prev_error_q <= '0;
			incr_accum_q <= '0;
			leaky_int_q  <= '0;
			out_valid_q  <= 1'b0;
			bit_q        <= '0;
			term_q       <= vpid_pkg::TERM_ERR;
		end else begin
			state_q <= state_d;
			if (state_q == vpid_pkg::S_CALC) begin
				bit_q  <= '0;
				term_q <= vpid_pkg::TERM_ERR;
			end else if (state_q == vpid_pkg::S_MUL) begin
				bit_q <= last_bit ? '0 : bit_q + 1'b1;
				if (last_bit)
					term_q <= term_nx;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				if (!skip_q) begin
					prev_error_q <= err_q;
					if (soft_mode_q)
						leaky_int_q <= leak_new_q;
					else
						incr_accum_q <= sum_c;
				end
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			sp_q  <= sample.target_speed;
			cnt_q <= sample.measured_count;
		end
		if (state_q == vpid_pkg::S_CALC) begin
			skip_q     <= sp_bad;
			err_q      <= err_c;
			derr_q     <= derr_c;
			leak_new_q <= leak_c;
			// standard mode adds onto the running accumulator
			acc_q      <= soft_mode_q ? '0 : vpid_pkg::ACC_W'(incr_accum_q);
			mcand_q    <= vpid_pkg::ACC_W'(err_c);
			gain_q     <= soft_mode_q ? gain_p_soft_q : {1'b0, gain_p_std_q};
		end else if (state_q == vpid_pkg::S_MUL) begin
			if (gain_q[0])
				acc_q <= acc_q + mcand_q;
			if (last_bit) begin
				mcand_q <= op_nx;
				gain_q  <= gain_nx;
			end else begin
				mcand_q <= mcand_q <<< 1;
				gain_q  <= gain_q >> 1;
			end
		end
		if (finish)
			// arithmetic shift right by 6 of the saturated sum
			drive_q <= skip_q ? '0 : sum_c[vpid_pkg::SUM_W-1:vpid_pkg::LEAK_SHIFT];
	end

endmodule

@@ hw/rtl/vpid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_checker: port-level checks of the velocity PID
// Bound to the top level; watches handshakes and the drive range.
// ----------------------------------------------------------------------------
module vpid_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [vpid_pkg::DRIVE_W-1:0] drive_value,
	input logic                                pready
);

	// register port never waits
	a_pready: assert property (@(posedge clk) pready)
		else $error("pready dropped");

	// an accepted sample keeps the controller busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("sample accepted while computing");

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(drive_value)))
		else $error("stalled drive value changed");

	// saturated sum never reaches the most negative code
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_value != -8'sd128))
		else $error("drive value out of range");

endmodule

bind velocity_pid_two_mode vpid_checker u_vpid_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (drive.valid),
	.out_ready   (drive.ready),
	.drive_value (drive.drive_value),
	.pready      (pready)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the two-mode velocity PID
// Drives setpoint/count samples, APB register writes and reads, predicts each
// drive value in step with the block and compares every drive transaction in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int COUNT_WIDTH  = vpid_pkg::COUNT_WIDTH_DEF;
	localparam int CLK_PERIOD   = 2;
	localparam int RESET_CYCLES = 10;
	localparam int IDLE_LIMIT   = 2000;  // cycles without any transaction
	localparam int HOLD_LEN     = 300;   // long drive stall of the pressure test
	localparam int DRAIN_CYCLES = 40;    // quiet cycles before the verdict
	localparam int COUNT_SCALE  = 4;     // encoder clicks per setpoint unit
	localparam int LEAK_NUM     = 63;
	localparam int LEAK_DEN     = 64;
	localparam int DRIVE_SHIFT  = 6;
	localparam int NUM_REGS     = 7;
	localparam logic [2:0] REG_UNMAPPED = 3'd7;
	localparam int CFG_MASK [NUM_REGS] = '{1, 15, 15, 31, 31, 31, 127};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [vpid_pkg::PADDR_W-1:0]  paddr;
	logic [vpid_pkg::PDATA_W-1:0]  pwdata;
	logic [vpid_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	vpid_in_if #(.COUNT_WIDTH(COUNT_WIDTH)) sample_if ();
	vpid_out_if                             drive_if ();

	velocity_pid_two_mode #(.COUNT_WIDTH(COUNT_WIDTH)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_if),
		.drive   (drive_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Register mirror and controller state of the predictor
	int                                 cfg [NUM_REGS];
	logic signed [vpid_pkg::ERR_W-1:0]  err_last;
	logic signed [vpid_pkg::SUM_W-1:0]  acc_std;
	logic signed [vpid_pkg::INT_W-1:0]  integ_soft;

	logic signed [vpid_pkg::DRIVE_W-1:0] pending_drive [$];
	int                                  n_errors;

	// Idling controls
	bit src_gaps;
	bit sink_stalls;
	int hold_req;
	int hold_seen;
	int hold_cycles;
	int stall_left;
	int idle_cycles;

	function automatic int clip(input int v, input int lo, input int hi);
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Advance the controller by one sample and return the drive value it gives
	function automatic logic signed [vpid_pkg::DRIVE_W-1:0] compute_drive(
		input logic signed [vpid_pkg::SP_W-1:0] sp_in,
		input logic signed [COUNT_WIDTH-1:0]    cnt_in
	);
		int sp;
		int cnt;
		int cap;
		int err;
		int derr;
		int integ;
		int sum;
		sp  = sp_in;
		cnt = cnt_in;
		// Out-of-range or stop setpoint: drive zero, state untouched
		if (sp > vpid_pkg::SET_MAX || sp < -vpid_pkg::SET_MAX || sp == 0)
			return '0;
		// Soft mode clamps the setpoint first; a cap of zero forces it to zero
		if (cfg[vpid_pkg::REG_SOFT_MODE] != 0) begin
			cap = cfg[vpid_pkg::REG_SPEED_CAP];
			sp  = clip(sp, -cap, cap);
		end
		err      = clip(sp * COUNT_SCALE - cnt, vpid_pkg::ERR_MIN, vpid_pkg::ERR_MAX);
		derr     = err - int'(err_last);
		err_last = vpid_pkg::ERR_W'(err);
		if (cfg[vpid_pkg::REG_SOFT_MODE] != 0) begin
			// Leak toward zero by truncating division, then add and bound
			integ      = int'(integ_soft);
			integ      = clip(integ * LEAK_NUM / LEAK_DEN + err,
				-vpid_pkg::INT_BOUND, vpid_pkg::INT_BOUND);
			integ_soft = vpid_pkg::INT_W'(integ);
			sum = clip(err * cfg[vpid_pkg::REG_GAIN_P_SOFT]
				+ integ * cfg[vpid_pkg::REG_GAIN_I_SOFT]
				+ derr * cfg[vpid_pkg::REG_GAIN_D_SOFT],
				-vpid_pkg::OUT_BOUND, vpid_pkg::OUT_BOUND);
		end else begin
			sum = clip(int'(acc_std) + err * cfg[vpid_pkg::REG_GAIN_P_STD]
				+ derr * cfg[vpid_pkg::REG_GAIN_D_STD],
				-vpid_pkg::OUT_BOUND, vpid_pkg::OUT_BOUND);
			acc_std = vpid_pkg::SUM_W'(sum);
		end
		// Arithmetic shift floors toward minus infinity
		return vpid_pkg::DRIVE_W'(sum >>> DRIVE_SHIFT);
	endfunction

	// Predict at every accepted sample transaction
	always @(posedge clk) begin
		if (arst_n && sample_if.valid && sample_if.ready)
			pending_drive.push_back(compute_drive(sample_if.target_speed,
				sample_if.measured_count));
	end

	// Compare every accepted drive transaction with the oldest prediction
	always @(posedge clk) begin
		logic signed [vpid_pkg::DRIVE_W-1:0] want;
		if (arst_n && drive_if.valid && drive_if.ready) begin
			if (pending_drive.size() == 0) begin
				$error("drive_value: no result pending, actual %0d", drive_if.drive_value);
				n_errors++;
			end else begin
				want = pending_drive.pop_front();
				if (drive_if.drive_value !== want) begin
					$error("drive_value: expected %0d, actual %0d", want,
						drive_if.drive_value);
					n_errors++;
				end
			end
		end
	end

	// Drive-side ready: a requested long hold-off, random stall bursts, else ready
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen   = hold_req;
			hold_cycles = HOLD_LEN;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			drive_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			drive_if.ready <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			drive_if.ready <= 1'b0;
		end else begin
			drive_if.ready <= 1'b1;
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((sample_if.valid && sample_if.ready) || (drive_if.valid && drive_if.ready)
			|| (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one sample and hold it until the block takes it; valid stays high
	task automatic send_sample(
		input logic signed [vpid_pkg::SP_W-1:0] sp,
		input logic signed [COUNT_WIDTH-1:0]    cnt
	);
		int gap;
		gap = 0;
		if (src_gaps && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		repeat (gap) begin
			@(negedge clk);
			sample_if.valid <= 1'b0;
		end
		@(negedge clk);
		sample_if.valid          <= 1'b1;
		sample_if.target_speed   <= sp;
		sample_if.measured_count <= cnt;
		do
			@(posedge clk);
		while (!sample_if.ready);
	endtask

	// Drop valid right after the last transaction and wait for every result
	task automatic wait_drained();
		@(negedge clk);
		sample_if.valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx,
		input logic [vpid_pkg::PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		// Unmapped indexes are ignored by the block
		if (idx <= vpid_pkg::REG_SPEED_CAP)
			cfg[idx] = int'(value) & CFG_MASK[idx];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_reg(input logic [2:0] idx,
		output logic [vpid_pkg::PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int mode, input int kp_std, input int kd_std,
		input int kp_soft, input int ki_soft, input int kd_soft, input int cap);
		write_reg(vpid_pkg::REG_SOFT_MODE,   mode);
		write_reg(vpid_pkg::REG_GAIN_P_STD,  kp_std);
		write_reg(vpid_pkg::REG_GAIN_D_STD,  kd_std);
		write_reg(vpid_pkg::REG_GAIN_P_SOFT, kp_soft);
		write_reg(vpid_pkg::REG_GAIN_I_SOFT, ki_soft);
		write_reg(vpid_pkg::REG_GAIN_D_SOFT, kd_soft);
		write_reg(vpid_pkg::REG_SPEED_CAP,   cap);
	endtask

	// Mostly tracking samples (count near setpoint scale), some stops and noise
	task automatic send_random(input int n, input int noise_pct);
		int k;
		int r;
		int v;
		int c;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			v = $urandom_range(1, vpid_pkg::SET_MAX);
			if ($urandom_range(0, 1))
				v = -v;
			if ($urandom_range(0, 9) == 0)
				v = (v < 0) ? -vpid_pkg::SET_MAX : vpid_pkg::SET_MAX;
			c = v * COUNT_SCALE + int'($urandom_range(0, 128)) - 64;
			if (r < noise_pct / 2)
				send_sample(vpid_pkg::SP_W'($urandom), COUNT_WIDTH'($urandom));
			else if (r < noise_pct)
				send_sample(vpid_pkg::SP_W'(v), COUNT_WIDTH'($urandom));
			else if (r < noise_pct + 3)
				send_sample('0, COUNT_WIDTH'(c));
			else
				send_sample(vpid_pkg::SP_W'(v), COUNT_WIDTH'(c));
		end
	endtask

	// Reset configuration, standard mode: field extremes, stop and bad setpoints
	task automatic test_standard_extremes();
		send_sample(vpid_pkg::SP_W'(vpid_pkg::SET_MAX), COUNT_WIDTH'(0));
		send_sample(vpid_pkg::SP_W'(vpid_pkg::SET_MAX), COUNT_WIDTH'(2047));
		send_sample(vpid_pkg::SP_W'(-vpid_pkg::SET_MAX), COUNT_WIDTH'(-2048));
		send_sample(vpid_pkg::SP_W'(-vpid_pkg::SET_MAX), COUNT_WIDTH'(2047));
		send_sample(vpid_pkg::SP_W'(1), COUNT_WIDTH'(4));
		send_sample(vpid_pkg::SP_W'(-1), COUNT_WIDTH'(-4));
		send_sample(vpid_pkg::SP_W'(0), COUNT_WIDTH'(123));
		send_sample(vpid_pkg::SP_W'(vpid_pkg::SET_MAX + 1), COUNT_WIDTH'(0));
		send_sample(vpid_pkg::SP_W'(-vpid_pkg::SET_MAX - 1), COUNT_WIDTH'(0));
		send_sample(vpid_pkg::SP_W'(127), COUNT_WIDTH'(-2048));
		send_sample(vpid_pkg::SP_W'(-128), COUNT_WIDTH'(2047));
	endtask

	// Soft mode: zero cap, cap above the setpoint range, integral at its bound
	task automatic test_soft_special();
		wait_drained();
		configure(1, 3, 4, 8, 8, 16, 0);
		send_sample(vpid_pkg::SP_W'(50), COUNT_WIDTH'(300));
		send_sample(vpid_pkg::SP_W'(-50), COUNT_WIDTH'(-300));
		wait_drained();
		write_reg(vpid_pkg::REG_SPEED_CAP, 127);
		send_sample(vpid_pkg::SP_W'(vpid_pkg::SET_MAX), COUNT_WIDTH'(-2048));
		send_sample(vpid_pkg::SP_W'(vpid_pkg::SET_MAX), COUNT_WIDTH'(-2048));
		send_sample(vpid_pkg::SP_W'(-vpid_pkg::SET_MAX), COUNT_WIDTH'(2047));
		send_sample(vpid_pkg::SP_W'(-vpid_pkg::SET_MAX), COUNT_WIDTH'(2047));
		send_sample(vpid_pkg::SP_W'(0), COUNT_WIDTH'(0));
		wait_drained();
		write_reg(vpid_pkg::REG_SPEED_CAP, 25);
		send_sample(vpid_pkg::SP_W'(vpid_pkg::SET_MAX), COUNT_WIDTH'(0));
		send_sample(vpid_pkg::SP_W'(-vpid_pkg::SET_MAX), COUNT_WIDTH'(0));
	endtask

	// Random register values, one write to an unmapped index, then read back
	task automatic test_register_map();
		logic [vpid_pkg::PDATA_W-1:0] rd;
		int                           i;
		vpid_pkg::reg_idx_t           ri;
		wait_drained();
		configure($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
			$urandom_range(0, 127));
		write_reg(REG_UNMAPPED, $urandom);
		for (i = 0; i < NUM_REGS; i++) begin
			read_reg(3'(i), rd);
			if (rd !== vpid_pkg::PDATA_W'(cfg[i])) begin
				ri = vpid_pkg::reg_idx_t'(i);
				$error("%s: expected %0d, actual %0d", ri.name(), cfg[i], rd);
				n_errors++;
			end
		end
	endtask

	// Phases of random samples under changing gains, modes and caps
	task automatic test_random_phases();
		int p;
		for (p = 0; p < 10; p++) begin
			wait_drained();
			case (p)
				0: configure(0, 0, 0, 0, 0, 0, 0);
				1: configure(1, 15, 15, 31, 31, 31, 0);
				2: configure(0, 15, 15, 31, 31, 31, 127);
				3: configure(1, 0, 0, 0, 0, 0, 127);
				default: configure($urandom_range(0, 1), $urandom_range(0, 15),
					$urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 127));
			endcase
			send_random(160, 20);
		end
	endtask

	// Hold the drive channel off while samples keep coming, so the input stalls
	task automatic test_backpressure();
		src_gaps = 1'b0;
		@(posedge clk);
		hold_req++;
		send_random(40, 0);
		src_gaps = 1'b1;
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_full_rate();
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		send_random(200, 10);
	endtask

	initial begin
		arst_n                   = 1'b0;
		psel                     = 1'b0;
		penable                  = 1'b0;
		pwrite                   = 1'b0;
		paddr                    = '0;
		pwdata                   = '0;
		sample_if.valid          = 1'b0;
		sample_if.target_speed   = '0;
		sample_if.measured_count = '0;
		drive_if.ready           = 1'b0;
		cfg = '{int'(vpid_pkg::RST_SOFT_MODE), int'(vpid_pkg::RST_GAIN_P_STD),
			int'(vpid_pkg::RST_GAIN_D_STD), int'(vpid_pkg::RST_GAIN_P_SOFT),
			int'(vpid_pkg::RST_GAIN_I_SOFT), int'(vpid_pkg::RST_GAIN_D_SOFT),
			int'(vpid_pkg::RST_SPEED_CAP)};
		err_last    = '0;
		acc_std     = '0;
		integ_soft  = '0;
		n_errors    = 0;
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		hold_req    = 0;
		hold_seen   = 0;
		hold_cycles = 0;
		stall_left  = 0;
		idle_cycles = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_standard_extremes();
		test_soft_special();
		test_register_map();
		test_random_phases();
		test_backpressure();
		test_full_rate();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/vpid_pkg.sv
hw/rtl/vpid_if.sv
hw/rtl/velocity_pid_two_mode.sv
hw/rtl/vpid_checker.sv
tb/tb_top.sv
